FILE: rtl/core/pabb_pkg.sv
// Shared types, constants and command/status structs for the pending ack batch buffer.
package pabb_pkg;

	localparam int ACK_DEPTH = 8;
	localparam int IDX_W     = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
	localparam int CNT_W     = $clog2(ACK_DEPTH + 1);
	localparam int MAXC_W    = 4;
	localparam int RUN_W     = 4;
	localparam int CMP_W     = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_FLUSHED = 2'd1;
	localparam logic [1:0] KIND_TAKEN   = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef struct packed {
		logic              opcode;
		logic [63:0]       rpc_id;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic [MAXC_W-1:0] max_count;
	} req_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [63:0]      rpc_id_res;
		logic [15:0]      src_port_res;
		logic [15:0]      dst_port_res;
		logic [RUN_W-1:0] run_count;
		logic             last;
	} rsp_item_t;

	typedef struct packed {
		logic [63:0] rpc_id;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} ack_entry_t;

	typedef enum logic [1:0] {
		CNT_HOLD  = 2'd0,
		CNT_INC   = 2'd1,
		CNT_CLEAR = 2'd2,
		CNT_SUB   = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		SRC_HDR  = 2'd0,
		SRC_MEM  = 2'd1,
		SRC_ZERO = 2'd2
	} out_src_t;

	typedef struct packed {
		logic             cap;
		cnt_op_t          cnt_op;
		logic             load;
		out_src_t         src;
		logic [IDX_W-1:0] idx;
		logic [1:0]       kind;
		logic [CNT_W-1:0] run;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic             op_take;
		logic             full;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] take_n;
		logic             out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/pabb_dp.sv
// Datapath: entry store, entry count, header register and output register.
module pabb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pabb_pkg::req_item_t req_item,
	input  logic                rsp_stall,
	input  pabb_pkg::dp_cmd_t   cmd,
	output pabb_pkg::dp_sts_t   sts,
	output logic                rsp_valid,
	output pabb_pkg::rsp_item_t rsp_item
);
	import pabb_pkg::*;

	ack_entry_t       mem_q [ACK_DEPTH];
	ack_entry_t       hdr_q;
	ack_entry_t       in_entry;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	rsp_item_t        out_q;
	logic [CMP_W-1:0] mc_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CNT_W-1:0] take_n;

	assign in_entry.rpc_id   = req_item.rpc_id;
	assign in_entry.src_port = req_item.src_port;
	assign in_entry.dst_port = req_item.dst_port;

	// clamp the requested take to what is stored
	assign mc_w   = CMP_W'(req_item.max_count);
	assign cnt_w  = CMP_W'(count_q);
	assign take_n = (mc_w < cnt_w) ? CNT_W'(mc_w) : count_q;

	assign sts.op_take  = (req_item.opcode == OP_TAKE);
	assign sts.full     = (count_q == CNT_W'(ACK_DEPTH));
	assign sts.count    = count_q;
	assign sts.take_n   = take_n;
	assign sts.out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:   count_q <= count_q + CNT_W'(1);
				CNT_CLEAR: count_q <= '0;
				CNT_SUB:   count_q <= count_q - take_n;
				default:   count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_op == CNT_INC) begin
			mem_q[count_q[IDX_W-1:0]] <= in_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			hdr_q <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.kind      <= cmd.kind;
			out_q.run_count <= RUN_W'(cmd.run);
			out_q.last      <= cmd.last;
			case (cmd.src)
				SRC_HDR: begin
					out_q.rpc_id_res   <= hdr_q.rpc_id;
					out_q.src_port_res <= hdr_q.src_port;
					out_q.dst_port_res <= hdr_q.dst_port;
				end
				SRC_MEM: begin
					out_q.rpc_id_res   <= mem_q[cmd.idx].rpc_id;
					out_q.src_port_res <= mem_q[cmd.idx].src_port;
					out_q.dst_port_res <= mem_q[cmd.idx].dst_port;
				end
				default: begin
					out_q.rpc_id_res   <= '0;
					out_q.src_port_res <= '0;
					out_q.dst_port_res <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ACK_DEPTH))
		else $error("entry count above depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || !rsp_stall))
		else $error("output register overwritten while a result waits");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cnt_op == CNT_INC) |-> (count_q < CNT_W'(ACK_DEPTH)))
		else $error("store write with no room");

endmodule

FILE: rtl/core/pabb_ctrl.sv
// Controller: sequences store writes, flush runs and take runs.
module pabb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pabb_pkg::dp_sts_t sts,
	output pabb_pkg::dp_cmd_t cmd
);
	import pabb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HEAD = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_NONE = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] end_idx_q;
	logic [CNT_W-1:0] run_q;
	logic [1:0]       kind_q;
	logic             run_last;

	assign req_stall = (state_q != ST_IDLE);
	assign run_last  = (idx_q == end_idx_q);

	always_comb begin
		cmd        = '0;
		cmd.cnt_op = CNT_HOLD;
		cmd.src    = SRC_ZERO;
		cmd.idx    = idx_q;
		cmd.kind   = kind_q;
		cmd.run    = run_q;
		state_nxt  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					if (!sts.op_take) begin
						if (!sts.full) begin
							cmd.cnt_op = CNT_INC;
						end else begin
							cmd.cnt_op = CNT_CLEAR;
							state_nxt  = ST_HEAD;
						end
					end else if (sts.take_n == '0) begin
						state_nxt = ST_NONE;
					end else begin
						cmd.cnt_op = CNT_SUB;
						state_nxt  = ST_RUN;
					end
				end
			end
			ST_HEAD: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					cmd.src   = SRC_HDR;
					cmd.kind  = KIND_HEADER;
					cmd.last  = (run_q == '0);
					state_nxt = (run_q == '0) ? ST_IDLE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.src  = SRC_MEM;
					cmd.last = run_last;
					if (run_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_NONE: begin
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					cmd.src   = SRC_ZERO;
					cmd.kind  = KIND_NONE;
					cmd.run   = '0;
					cmd.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// run bookkeeping: set up at accept, advance per loaded stored entry
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			end_idx_q <= IDX_W'(sts.count - CNT_W'(1));
			if (!sts.op_take) begin
				idx_q  <= '0;
				run_q  <= sts.count;
				kind_q <= KIND_FLUSHED;
			end else begin
				idx_q  <= IDX_W'(sts.count - sts.take_n);
				run_q  <= sts.take_n;
				kind_q <= KIND_TAKEN;
			end
		end else if (state_q == ST_RUN && sts.out_free && !run_last) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= end_idx_q))
		else $error("run index past end of run");

	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cmd.cnt_op == CNT_HOLD))
		else $error("entry count changed during a run");

endmodule

FILE: rtl/core/pending_ack_batch_buffer.sv
// Top level of the pending acknowledgement batch buffer.
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_stall   req_item (opcode, entry, max_count)
//  rsp       out        rsp_valid / rsp_stall   rsp_item (kind, entry, run_count, last)
//
// An add that finds room gives no result; with req_stall low, adds can follow every cycle.
// A flush of the N stored entries loads a header for the new item, then one result per stored
// entry; a take of n entries loads n results, a take of nothing a single result. With rsp_stall
// low, one result per cycle is set by the single read port of the entry store feeding the
// output register. Reset clears the entry count and the output valid; store contents are
// undefined and need no clearing pass. rsp_stall holds the output register and pauses the run;
// req_stall stays high from the accept of an item with results until its last result is loaded.
module pending_ack_batch_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pabb_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pabb_pkg::rsp_item_t rsp_item
);
	import pabb_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence accepts, count updates and result loads
	pabb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the entries, the count and the outgoing result item
	pabb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

endmodule
